[rtl/fpr8_pkg.sv]
// shared types and constants for the float pixel to rgba8 converter
`default_nettype none
package fpr8_pkg;
  localparam int unsigned ChanW = 32;
  localparam int unsigned SelW = 2;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 2;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_RED_SRC   = 3'd0,
    CFG_GREEN_SRC = 3'd1,
    CFG_BLUE_SRC  = 3'd2,
    CFG_ALPHA_SRC = 3'd3,
    CFG_ALPHA_EN  = 3'd4,
    CFG_GRAY_EN   = 3'd5
  } cfg_idx_e;

  // product of the 24-bit significand with 255 and its exponent
  typedef struct packed {
    logic        zero;
    logic        one;
    logic [31:0] prod;
    logic [7:0]  expo;
  } fpr8_mul_t;

  localparam logic [ByteW-1:0] OpaqueAlpha = 8'd255;
endpackage
`default_nettype wire

[rtl/fpr8_conv.sv]
// three-stage single precision to unorm8 converter for one component
`default_nettype none
module fpr8_conv
  import fpr8_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [ChanW-1:0] bits_i,
  output logic      [ByteW-1:0] byte_o
);
  // stage 1: classify and multiply significand by 255
  fpr8_mul_t m_d, m_q;
  logic [7:0] e_in;
  always_comb begin
    e_in = bits_i[30:23];
    m_d.zero = (e_in == 8'hff) || bits_i[31] || (e_in == 8'd0);
    m_d.one = !m_d.zero && (e_in >= 8'd127);
    m_d.prod = {1'b1, bits_i[22:0]} * 32'd255;
    m_d.expo = e_in;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_q <= '0;
    else if (en_i) m_q <= m_d;
  end

  // stage 2: round v*255 to 24 significant bits (rne) in fixed point
  // value = prod * 2^(expo-150); keep fixed point with 24 fraction bits
  logic [31:0] p;
  logic        top;
  logic [4:0]  sh;
  logic [31:0] keep, rem, half, rounded, fixd;
  logic [55:0] wide;
  logic [31:0] fix_d, fix_q;
  logic        one_q, zero_q;
  always_comb begin
    p = m_q.prod;
    top = p[31];
    sh = top ? 5'd8 : 5'd7;            // drop bits beyond 24 significant
    keep = p >> sh;
    rem = p & ((32'd1 << sh) - 32'd1);
    half = 32'd1 << (sh - 5'd1);
    rounded = keep + {31'd0, (rem > half) || ((rem == half) && keep[0])};
    fixd = rounded << sh;              // may carry to 2^32 only via 25 bits
    wide = {24'd0, fixd} << 24;
    // shift right by 150-expo, exponent below 127 so at least 24
    fix_d = 32'(wide >> (8'd150 - m_q.expo));
    if (m_q.expo < 8'd100) fix_d = '0;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_q <= '0; one_q <= 1'b0; zero_q <= 1'b1;
    end else if (en_i) begin
      fix_q <= fix_d; one_q <= m_q.one; zero_q <= m_q.zero;
    end
  end

  // stage 3: add 0.5 with float rounding, then truncate
  // fix_q holds v*255 with 24 fraction bits, below 255
  logic [7:0]  ip;
  logic [23:0] fr;
  logic [ByteW-1:0] b_d, b_q;
  logic [4:0]  ulp;
  logic [23:0] lsbmask;
  logic [24:0] s;
  logic [7:0]  r;
  always_comb begin
    ip = fix_q[31:24];
    fr = fix_q[23:0];
    // result near ip+0.5 has exponent of ip (or 1 for ip=0)
    ulp = 5'd0;
    for (int k = 0; k < 8; k++) if (ip[k]) ulp = 5'(k + 1);
    if (ip == 8'd0) ulp = 5'd1;
    s = {1'b0, fr} + 25'h0800000;
    lsbmask = 24'hffffff >> (5'd24 - ulp);
    // truncation after rounding: integer part ip plus carry of rounded fraction
    r = ip + {7'd0, s[24]};
    // rounding of sum to (24-ulp) fraction bits can carry into integer
    if (!s[24] && ((s[23:0] | lsbmask) == 24'hffffff)) begin
      if ((s[23:0] & lsbmask) > (lsbmask >> 1)) r = r + 8'd1;
      else if (((s[23:0] & lsbmask) == ((lsbmask >> 1) + 24'd1)) &&
               (((s[23:0] >> ulp) & 24'd1) == 24'd1)) r = r + 8'd1;
    end
    b_d = zero_q ? 8'd0 : (one_q ? 8'd255 : r);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_q <= '0;
    else if (en_i) b_q <= b_d;
  end
  assign byte_o = b_q;
endmodule
`default_nettype wire

[rtl/float_pixel_to_rgba8_top.sv]
// Float pixel to RGBA8 converter: up to four float32 channels in, one 8-bit RGBA pixel out.
// Throughput is one pixel per cycle unless the output stalls; there are three converter stages
// (classify and multiply by 255, rounding to single precision, add one half and truncate),
// and the last stage is the output register. The pipeline advances whenever the output is
// empty or being taken, so a stall holds every stage. Configure only while idle.
`default_nettype none
module float_pixel_to_rgba8_top
  import fpr8_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [ChanW-1:0]    channel_zero_i,
  input  wire logic [ChanW-1:0]    channel_one_i,
  input  wire logic [ChanW-1:0]    channel_two_i,
  input  wire logic [ChanW-1:0]    channel_three_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [ByteW-1:0]         red_byte_o,
  output logic [ByteW-1:0]         green_byte_o,
  output logic [ByteW-1:0]         blue_byte_o,
  output logic [ByteW-1:0]         alpha_byte_o
);
  logic [SelW-1:0] red_src_q, green_src_q, blue_src_q, alpha_src_q;
  logic alpha_en_q, gray_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_src_q <= 2'd0; green_src_q <= 2'd1; blue_src_q <= 2'd2; alpha_src_q <= 2'd3;
      alpha_en_q <= 1'b0; gray_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RED_SRC:   red_src_q <= cfg_data_i;
        CFG_GREEN_SRC: green_src_q <= cfg_data_i;
        CFG_BLUE_SRC:  blue_src_q <= cfg_data_i;
        CFG_ALPHA_SRC: alpha_src_q <= cfg_data_i;
        CFG_ALPHA_EN:  alpha_en_q <= cfg_data_i[0];
        CFG_GRAY_EN:   gray_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [ChanW-1:0] chans [4];
  assign chans[0] = channel_zero_i;
  assign chans[1] = channel_one_i;
  assign chans[2] = channel_two_i;
  assign chans[3] = channel_three_i;

  function automatic logic [ChanW-1:0] pick(input logic [SelW-1:0] s,
                                            input logic [ChanW-1:0] c0,
                                            input logic [ChanW-1:0] c1,
                                            input logic [ChanW-1:0] c2,
                                            input logic [ChanW-1:0] c3,
                                            input int unsigned nmax);
    logic [ChanW-1:0] v;
    case (s)
      2'd0: v = c0;
      2'd1: v = c1;
      2'd2: v = c2;
      default: v = c3;
    endcase
    if (32'(s) >= nmax) v = '0;
    return v;
  endfunction

  logic [ChanW-1:0] r_bits, g_bits, b_bits, a_bits;
  assign r_bits = pick(red_src_q, chans[0], chans[1], chans[2], chans[3], MAX_CHANNELS);
  assign g_bits = pick(gray_en_q ? red_src_q : green_src_q,
                       chans[0], chans[1], chans[2], chans[3], MAX_CHANNELS);
  assign b_bits = pick(gray_en_q ? red_src_q : blue_src_q,
                       chans[0], chans[1], chans[2], chans[3], MAX_CHANNELS);
  assign a_bits = pick(alpha_src_q, chans[0], chans[1], chans[2], chans[3], MAX_CHANNELS);

  // valid pipeline, three converter stages; last stage is the output register
  logic [2:0] vld_q;
  logic [2:0] aen_q;
  logic en;
  assign en = !vld_q[2] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0; aen_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[1:0], in_valid_i};
      aen_q <= {aen_q[1:0], alpha_en_q};
    end
  end

  logic [ByteW-1:0] rb, gb, bb, ab;
  fpr8_conv u_r (.clk_i, .rst_ni, .en_i(en), .bits_i(r_bits), .byte_o(rb));
  fpr8_conv u_g (.clk_i, .rst_ni, .en_i(en), .bits_i(g_bits), .byte_o(gb));
  fpr8_conv u_b (.clk_i, .rst_ni, .en_i(en), .bits_i(b_bits), .byte_o(bb));
  fpr8_conv u_a (.clk_i, .rst_ni, .en_i(en), .bits_i(a_bits), .byte_o(ab));

  assign out_valid_o = vld_q[2];
  assign red_byte_o = rb;
  assign green_byte_o = gb;
  assign blue_byte_o = bb;
  assign alpha_byte_o = aen_q[2] ? ab : OpaqueAlpha;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_byte_o))
    else $error("output changed during stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("not ready with empty output");
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !aen_q[2] |-> alpha_byte_o == OpaqueAlpha)
    else $error("alpha not opaque");
`endif
endmodule
`default_nettype wire

[dv/tb_top.sv]
// testbench for float_pixel_to_rgba8_top: directed and random pixels against a bit-exact predictor
`default_nettype none
module tb_top;
  import fpr8_pkg::*;

  localparam logic [CfgAddrW-1:0] UNMAPPED_IDX_LO = 3'd6;
  localparam logic [CfgAddrW-1:0] UNMAPPED_IDX_HI = 3'd7;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] alpha;
  } rgba8_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ChanW-1:0]    chan_i [4];
  logic                out_valid_o;
  logic                out_ready_i;
  logic [ByteW-1:0]    red_byte_o;
  logic [ByteW-1:0]    green_byte_o;
  logic [ByteW-1:0]    blue_byte_o;
  logic [ByteW-1:0]    alpha_byte_o;

  float_pixel_to_rgba8_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .channel_zero_i (chan_i[0]),
    .channel_one_i  (chan_i[1]),
    .channel_two_i  (chan_i[2]),
    .channel_three_i(chan_i[3]),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_byte_o     (red_byte_o),
    .green_byte_o   (green_byte_o),
    .blue_byte_o    (blue_byte_o),
    .alpha_byte_o   (alpha_byte_o)
  );

  // shadow of the mapping registers
  logic [SelW-1:0] src_sel [4];
  logic            alpha_en;
  logic            gray_en;

  rgba8_t pending_pixels [$];
  int     mismatches;
  int     pixels_sent;
  int     pixels_checked;
  bit     no_idle;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // round a fixed-point value to 24 significant bits, nearest even
  function automatic logic [63:0] round_to_single(input logic [63:0] x);
    int          msb;
    int          drop;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    msb = 0;
    for (int i = 0; i < 64; i++) if (x[i]) msb = i;
    if (msb <= 23) return x;
    drop = msb - 23;
    keep = x >> drop;
    rem  = x & ((64'd1 << drop) - 1);
    half = 64'd1 << (drop - 1);
    if (rem > half || (rem == half && keep[0])) keep = keep + 1;
    return keep << drop;
  endfunction

  // float32 pattern to unorm8; fixed point with 40 fraction bits
  function automatic logic [ByteW-1:0] float_to_unorm8(input logic [ChanW-1:0] f);
    logic [7:0]  expo;
    logic [63:0] prod;
    logic [63:0] sum;
    expo = f[30:23];
    if (expo == 8'hFF || f[31]) return 8'd0;
    if (f[30:0] > 31'h3F800000) return 8'd255;
    // below 2^-10 the biased sum stays under one
    if (expo < 8'd117) return 8'd0;
    prod = (64'({1'b1, f[22:0]}) * 64'd255) << (expo - 8'd110);
    sum  = round_to_single(round_to_single(prod) + (64'd1 << 39));
    sum  = sum >> 40;
    return (sum > 64'd255) ? 8'd255 : sum[7:0];
  endfunction

  function automatic rgba8_t predict_pixel(input logic [ChanW-1:0] c0, c1, c2, c3);
    logic [ChanW-1:0] ch [4];
    rgba8_t           px;
    ch = '{c0, c1, c2, c3};
    px.red   = float_to_unorm8(ch[src_sel[CFG_RED_SRC]]);
    px.green = gray_en ? px.red : float_to_unorm8(ch[src_sel[CFG_GREEN_SRC]]);
    px.blue  = gray_en ? px.red : float_to_unorm8(ch[src_sel[CFG_BLUE_SRC]]);
    px.alpha = alpha_en ? float_to_unorm8(ch[src_sel[CFG_ALPHA_SRC]]) : OpaqueAlpha;
    return px;
  endfunction

  function automatic logic [ChanW-1:0] rand_channel();
    logic [22:0] mant;
    mant = ($urandom_range(15) == 0) ? 23'd0 : 23'($urandom);
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2, 3, 4: return {1'b0, 8'($urandom_range(126, 117)), mant};
      5:       return $urandom_range(1) ? 32'h3F800000 : 32'h00000000;
      6:       return {1'($urandom_range(1)), 8'hFF, mant};
      7:       return {1'b1, 31'($urandom)};
      8:       return {1'b0, 8'($urandom_range(254, 127)), mant};
      default: return {1'b0, 8'($urandom_range(116, 0)), mant};
    endcase
  endfunction

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_pixel(input logic [ChanW-1:0] c0, c1, c2, c3);
    if (!no_idle && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 17);
    end
    in_valid_i <= 1'b1;
    chan_i[0]  <= c0;
    chan_i[1]  <= c1;
    chan_i[2]  <= c2;
    chan_i[3]  <= c3;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pixels.push_back(predict_pixel(c0, c1, c2, c3));
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // back-to-back writes keep the enable high; the caller lowers it afterwards
  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_RED_SRC, CFG_GREEN_SRC, CFG_BLUE_SRC, CFG_ALPHA_SRC: src_sel[idx] = data;
      CFG_ALPHA_EN: alpha_en = data[0];
      CFG_GRAY_EN:  gray_en  = data[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_mapping(input logic [SelW-1:0] r, g, b, a, input logic aen, gen);
    wait_drained();
    write_reg(CFG_RED_SRC, r);
    write_reg(CFG_GREEN_SRC, g);
    write_reg(CFG_BLUE_SRC, b);
    write_reg(CFG_ALPHA_SRC, a);
    write_reg(CFG_ALPHA_EN, {1'b0, aen});
    write_reg(CFG_GRAY_EN, {1'b0, gen});
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_special_values();
    logic [ChanW-1:0] specials [12];
    specials = '{32'h00000000, 32'h80000000, 32'h3F800000, 32'h3F800001,
                 32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'h7F800001,
                 32'h00000001, 32'h7F7FFFFF, 32'hFFFFFFFF, 32'h3F000000};
    set_mapping(2'd0, 2'd1, 2'd2, 2'd3, 1'b1, 1'b0);
    for (int i = 0; i < 12; i++)
      send_pixel(specials[i], specials[(i + 3) % 12], specials[(i + 6) % 12],
                 specials[(i + 9) % 12]);
    // one ulp either side of a rounding tie region
    send_pixel(32'h3B808081, 32'h3B808080, 32'h3F7FFFFF, 32'h00800000);
  endtask

  task automatic test_mappings();
    // gray on, alpha from channel 3 with all sources at the top index
    set_mapping(2'd3, 2'd3, 2'd3, 2'd3, 1'b1, 1'b1);
    repeat (3) send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel());
    set_mapping(2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 1'b0);
    repeat (3) send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel());
    // wide data on one-bit registers keeps the low bit; unmapped indexes do nothing
    wait_drained();
    write_reg(CFG_ALPHA_EN, 2'd3);
    write_reg(CFG_GRAY_EN, 2'd2);
    write_reg(UNMAPPED_IDX_LO, 2'd3);
    write_reg(UNMAPPED_IDX_HI, 2'd1);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    repeat (3) send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel());
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 8; phase++) begin
      set_mapping(2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom),
                  1'($urandom), ($urandom_range(3) == 0));
      no_idle = (phase == 3);
      repeat (205) send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel());
      no_idle = 1'b0;
    end
  endtask

  always @(negedge clk_i) out_ready_i <= no_idle || ($urandom_range(99) >= 17);

  always @(posedge clk_i) begin
    rgba8_t want;
    rgba8_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{red_byte_o, green_byte_o, blue_byte_o, alpha_byte_o};
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel transfer %h", got);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (want != got) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel %0d: expected r%h g%h b%h a%h, got r%h g%h b%h a%h",
                     pixels_checked, want.red, want.green, want.blue, want.alpha,
                     got.red, got.green, got.blue, got.alpha);
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_RED_SRC;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    chan_i      = '{default: '0};
    out_ready_i = 1'b0;
    no_idle     = 1'b0;
    mismatches  = 0;
    pixels_sent = 0;
    pixels_checked = 0;
    src_sel     = '{2'd0, 2'd1, 2'd2, 2'd3};
    alpha_en    = 1'b0;
    gray_en     = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // reset mapping first, before any write
    repeat (4) send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel());
    test_special_values();
    test_mappings();
    test_random_stream();
    wait_drained();
    $display("sent %0d pixels over 13 register settings, checked %0d, %0d mismatches",
             pixels_sent, pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout waiting for pixel transfers");
    $display("tb_top failed");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
rtl/fpr8_pkg.sv
rtl/fpr8_conv.sv
rtl/float_pixel_to_rgba8_top.sv
dv/tb_top.sv
